[hw/rtl/agsr_pkg.sv]
// ----------------------------------------------------------------------------
// agsr_pkg
// Shared types and codes for the analog gamepad serial responder.
// ----------------------------------------------------------------------------
package agsr_pkg;

  // Item kinds on the request channel
  localparam logic [1:0] OP_EXCHANGE    = 2'd0;
  localparam logic [1:0] OP_SNAPSHOT    = 2'd1;
  localparam logic [1:0] OP_SEL_RELEASE = 2'd2;

  // Internal command codes
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_READ   = 4'd1;
  localparam logic [3:0] CMD_ENTER  = 4'd2;
  localparam logic [3:0] CMD_EXIT   = 4'd3;
  localparam logic [3:0] CMD_LEDGET = 4'd4;
  localparam logic [3:0] CMD_LEDSET = 4'd5;
  localparam logic [3:0] CMD_RUMBLE = 4'd6;
  localparam logic [3:0] CMD_X46    = 4'd7;
  localparam logic [3:0] CMD_X47    = 4'd8;
  localparam logic [3:0] CMD_X4C    = 4'd9;

  // Host command bytes
  localparam logic [7:0] HB_START  = 8'h01;
  localparam logic [7:0] HB_READ   = 8'h42;
  localparam logic [7:0] HB_CONFIG = 8'h43;
  localparam logic [7:0] HB_LEDSET = 8'h44;
  localparam logic [7:0] HB_LEDGET = 8'h45;
  localparam logic [7:0] HB_X46    = 8'h46;
  localparam logic [7:0] HB_X47    = 8'h47;
  localparam logic [7:0] HB_X4C    = 8'h4C;
  localparam logic [7:0] HB_RUMBLE = 8'h4D;

  // Reply bytes
  localparam logic [7:0] ID_DIGITAL = 8'h41;
  localparam logic [7:0] ID_ANALOG  = 8'h73;
  localparam logic [7:0] ID_CONFIG  = 8'hF3;
  localparam logic [7:0] RX_ACK     = 8'h5A;
  localparam logic [7:0] RX_IDLE    = 8'hFF;
  localparam logic [7:0] STICK_CTR  = 8'h80;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  tx_byte;
    logic [15:0] pressed_buttons;
    logic [7:0]  left_stick_x;
    logic [7:0]  left_stick_y;
    logic [7:0]  right_stick_x;
    logic [7:0]  right_stick_y;
    logic        mode_button;
  } agsr_item_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       more_bytes;
    logic       analog_mode;
    logic       led_on;
    logic       config_mode;
  } agsr_result_t;

endpackage

[hw/rtl/agsr_channels.sv]
// ----------------------------------------------------------------------------
// agsr channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface agsr_in_if;
  logic               valid;
  logic               ready;
  agsr_pkg::agsr_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface agsr_out_if;
  logic                 valid;
  logic                 ready;
  agsr_pkg::agsr_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/analog_gamepad_serial_responder.sv]
// ----------------------------------------------------------------------------
// analog_gamepad_serial_responder
// Pad side of a controller serial link: one reply per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries requests: serial byte exchanges, pad snapshot updates and
//   select-released events. out_if returns one result per request: the reply
//   byte, the acknowledge bit and the analog, LED and config flags after it.
//   A request is taken when valid and ready are both high.
//   A request accepted at one edge is registered in the input stage, then
//   processed into the result register, which drives out_if.valid; a stall
//   of the receiver can hold it in the input stage between the two.
//   Throughput: one request per cycle unless the receiver stalls; pad state is
//   read and updated by one pass of decode logic between the stage registers.
//   Reset (rst_n low, synchronous) empties both stages, returns the sequence
//   to idle, clears modes, buttons and LED and centers the sticks.
//   When the receiver stalls, the result register holds its value, one more
//   request waits in the input stage, and in_if.ready drops once both are full.
// ----------------------------------------------------------------------------
module analog_gamepad_serial_responder (
  input logic        clk,
  input logic        rst_n,
  agsr_in_if.sink    in_if,
  agsr_out_if.source out_if
);

  logic                   in_valid_r;
  agsr_pkg::agsr_item_t   in_item_r;
  logic                   out_valid_r;
  agsr_pkg::agsr_result_t out_data_r;
  agsr_pkg::agsr_result_t result;
  logic                   advance;

  // Stage moves when the result register is free or being drained
  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  agsr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .result (result)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_item_r <= in_if.data;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

endmodule

[hw/rtl/agsr_core.sv]
// ----------------------------------------------------------------------------
// agsr_core
// Pad state and per-request decode: computes the reply and the next state
// for one request, commits the state when the request is processed.
// ----------------------------------------------------------------------------
module agsr_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  agsr_pkg::agsr_item_t   item,
  output agsr_pkg::agsr_result_t result
);

  logic [3:0]  step_r,    step_nxt;
  logic [3:0]  cmd_r,     cmd_nxt;
  logic        analog_r,  analog_nxt;
  logic        cfg_r,     cfg_nxt;
  logic        lamp_r,    lamp_nxt;
  logic [7:0]  arg_r,     arg_nxt;
  logic [15:0] buttons_r, buttons_nxt;
  logic [7:0]  sticks_r   [4];
  logic [7:0]  sticks_nxt [4];
  logic        held_r,    held_nxt;

  logic [7:0]  pad_byte;
  logic [3:0]  cmd_cur;
  logic [7:0]  rx;
  logic        p_one;
  logic        b_one;

  // Pad data byte for the current payload step
  always_comb begin
    unique case (step_r)
      4'd3:    pad_byte = ~buttons_r[7:0];
      4'd4:    pad_byte = ~buttons_r[15:8];
      4'd5:    pad_byte = sticks_r[2];
      4'd6:    pad_byte = sticks_r[3];
      4'd7:    pad_byte = sticks_r[0];
      default: pad_byte = sticks_r[1];
    endcase
  end

  assign p_one   = (arg_r == 8'd1);
  assign b_one   = (item.tx_byte == 8'd1);
  assign cmd_cur = (step_r == 4'd0) ? agsr_pkg::CMD_NONE : cmd_r;

  // Request decode and next state
  always_comb begin
    step_nxt    = step_r;
    cmd_nxt     = cmd_r;
    analog_nxt  = analog_r;
    cfg_nxt     = cfg_r;
    lamp_nxt    = lamp_r;
    arg_nxt     = arg_r;
    buttons_nxt = buttons_r;
    sticks_nxt  = sticks_r;
    held_nxt    = held_r;
    rx          = agsr_pkg::RX_IDLE;

    unique case (item.opcode)
      agsr_pkg::OP_EXCHANGE: begin
        if (step_r == 4'd0) cmd_nxt = agsr_pkg::CMD_NONE;
        if (cmd_cur != agsr_pkg::CMD_NONE) begin
          if (step_r < 4'd2 || step_r > 4'd8) begin
            rx = agsr_pkg::RX_IDLE;
          end else if (step_r == 4'd2) begin
            step_nxt = 4'd3;
            rx       = agsr_pkg::RX_ACK;
          end else begin
            // payload bytes, steps 3..8
            rx = 8'h00;
            unique case (cmd_cur)
              agsr_pkg::CMD_ENTER, agsr_pkg::CMD_EXIT: begin
                if (step_r == 4'd3) cfg_nxt = b_one;
                if (cmd_cur == agsr_pkg::CMD_ENTER) rx = pad_byte;
              end
              agsr_pkg::CMD_LEDSET: begin
                if (step_r == 4'd3) arg_nxt = item.tx_byte;
                if (step_r == 4'd4 && arg_r == 8'd2) lamp_nxt = b_one;
              end
              agsr_pkg::CMD_LEDGET: begin
                unique case (step_r)
                  4'd3:    rx = 8'd1;
                  4'd4:    rx = 8'd2;
                  4'd5:    rx = {7'd0, lamp_r};
                  4'd6:    rx = 8'd2;
                  4'd7:    rx = 8'd1;
                  default: rx = 8'd0;
                endcase
              end
              agsr_pkg::CMD_RUMBLE: begin
                if (step_r == 4'd8) analog_nxt = 1'b1;
              end
              agsr_pkg::CMD_X46: begin
                unique case (step_r)
                  4'd3: begin
                    arg_nxt = item.tx_byte;
                    rx      = 8'd0;
                  end
                  4'd4:    rx = 8'd0;
                  4'd5:    rx = 8'd1;
                  4'd6:    rx = p_one ? 8'd1 : 8'd2;
                  4'd7:    rx = p_one ? 8'd1 : 8'd0;
                  default: rx = p_one ? 8'h14 : 8'h0A;
                endcase
              end
              agsr_pkg::CMD_X47: begin
                unique case (step_r)
                  4'd5:    rx = 8'd2;
                  4'd7:    rx = 8'd1;
                  default: rx = 8'd0;
                endcase
              end
              agsr_pkg::CMD_X4C: begin
                if (step_r == 4'd3) arg_nxt = item.tx_byte;
                if (step_r == 4'd6) rx = p_one ? 8'h07 : 8'h04;
              end
              default: rx = pad_byte;
            endcase

            // sequence advance; in digital mode, read and config entry end after the button bytes
            if (step_r == 4'd8) begin
              step_nxt = 4'd0;
            end else if (step_r == 4'd4 && !analog_r &&
                         (cmd_cur == agsr_pkg::CMD_READ ||
                          cmd_cur == agsr_pkg::CMD_ENTER)) begin
              step_nxt = 4'd0;
            end else begin
              step_nxt = step_r + 4'd1;
            end
          end
        end else if (step_r == 4'd0) begin
          if (item.tx_byte == agsr_pkg::HB_START) step_nxt = 4'd1;
        end else if (step_r == 4'd1) begin
          // command select, a known command is answered with the pad ID
          priority if (item.tx_byte == agsr_pkg::HB_READ)
            cmd_nxt = agsr_pkg::CMD_READ;
          else if (item.tx_byte == agsr_pkg::HB_CONFIG)
            cmd_nxt = cfg_r ? agsr_pkg::CMD_EXIT : agsr_pkg::CMD_ENTER;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_LEDSET)
            cmd_nxt = agsr_pkg::CMD_LEDSET;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_LEDGET)
            cmd_nxt = agsr_pkg::CMD_LEDGET;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_X46)
            cmd_nxt = agsr_pkg::CMD_X46;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_X47)
            cmd_nxt = agsr_pkg::CMD_X47;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_RUMBLE)
            cmd_nxt = agsr_pkg::CMD_RUMBLE;
          else if (cfg_r && item.tx_byte == agsr_pkg::HB_X4C)
            cmd_nxt = agsr_pkg::CMD_X4C;
          else
            cmd_nxt = agsr_pkg::CMD_NONE;

          if (cmd_nxt == agsr_pkg::CMD_NONE) begin
            step_nxt = 4'd0;
          end else begin
            step_nxt = 4'd2;
            rx = cfg_r    ? agsr_pkg::ID_CONFIG :
                 analog_r ? agsr_pkg::ID_ANALOG : agsr_pkg::ID_DIGITAL;
          end
        end else begin
          step_nxt = 4'd0;
        end
      end

      agsr_pkg::OP_SNAPSHOT: begin
        // analog button edge toggles the mode and aborts the sequence
        if (item.mode_button) begin
          if (!held_r) begin
            held_nxt   = 1'b1;
            analog_nxt = !analog_r;
            lamp_nxt   = !analog_r;
            step_nxt   = 4'd0;
            cmd_nxt    = agsr_pkg::CMD_NONE;
          end
        end else begin
          held_nxt = 1'b0;
        end
        buttons_nxt = item.pressed_buttons;
        if (!analog_nxt) begin
          buttons_nxt[2:1] = 2'b00;
        end else begin
          sticks_nxt[0] = item.left_stick_x;
          sticks_nxt[1] = item.left_stick_y;
          sticks_nxt[2] = item.right_stick_x;
          sticks_nxt[3] = item.right_stick_y;
        end
      end

      agsr_pkg::OP_SEL_RELEASE: begin
        step_nxt = 4'd0;
        cmd_nxt  = agsr_pkg::CMD_NONE;
      end

      default: ;
    endcase
  end

  // Result fields reflect the state after the request
  assign result.rx_byte     = rx;
  assign result.more_bytes  = (item.opcode == agsr_pkg::OP_EXCHANGE) && (step_nxt != 4'd0);
  assign result.analog_mode = analog_nxt;
  assign result.led_on      = lamp_nxt;
  assign result.config_mode = cfg_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 4'd0;
      cmd_r     <= agsr_pkg::CMD_NONE;
      analog_r  <= 1'b0;
      cfg_r     <= 1'b0;
      lamp_r    <= 1'b0;
      arg_r     <= 8'd0;
      buttons_r <= 16'd0;
      held_r    <= 1'b0;
      for (int i = 0; i < 4; i++) sticks_r[i] <= agsr_pkg::STICK_CTR;
    end else if (fire) begin
      step_r    <= step_nxt;
      cmd_r     <= cmd_nxt;
      analog_r  <= analog_nxt;
      cfg_r     <= cfg_nxt;
      lamp_r    <= lamp_nxt;
      arg_r     <= arg_nxt;
      buttons_r <= buttons_nxt;
      held_r    <= held_nxt;
      sticks_r  <= sticks_nxt;
    end
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for analog_gamepad_serial_responder. A short table of directed
// requests covers the idle replies, unknown commands, digital and analog
// reads, mode button edges and the reserved opcode. Random command sequences,
// pad snapshots, select releases and stray bytes follow. A cycle-free model
// of the pad tracks the protocol state. Every reply is compared field by field
// in request order. Both channel sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode that the pad ignores
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Reply bytes of the 0x46 and 0x4C commands
  localparam logic [7:0] X46_ARG_ONE   = 8'h14;
  localparam logic [7:0] X46_ARG_OTHER = 8'h0A;
  localparam logic [7:0] X4C_ARG_ONE   = 8'h07;
  localparam logic [7:0] X4C_ARG_OTHER = 8'h04;
  localparam int         ITEM_TARGET   = 1150;
  localparam int         CALM_TAIL     = 150;

  typedef struct packed {
    agsr_pkg::agsr_item_t   item;
    logic                   typed;
    agsr_pkg::agsr_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  agsr_in_if  in_ch ();
  agsr_out_if out_ch ();

  analog_gamepad_serial_responder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pad state as the model sees it
  logic [3:0]  seq_step     = '0;
  logic [3:0]  cur_cmd      = agsr_pkg::CMD_NONE;
  logic        pad_analog   = 1'b0;
  logic        pad_config   = 1'b0;
  logic        pad_lamp     = 1'b0;
  logic [7:0]  cmd_arg      = '0;
  logic [15:0] pad_buttons  = '0;
  logic [7:0]  pad_sticks [4] = '{agsr_pkg::STICK_CTR, agsr_pkg::STICK_CTR,
                                  agsr_pkg::STICK_CTR, agsr_pkg::STICK_CTR};
  logic        mode_held    = 1'b0;

  agsr_pkg::agsr_result_t pending_replies [$];
  int           fail_count  = 0;
  int           sent_count  = 0;
  bit           idle_enable = 1'b1;
  int           stall_left  = 0;
  dir_row_t     directed_rows [26];

  // Button and stick bytes in report order
  function automatic logic [7:0] pad_report_byte(input logic [3:0] s);
    case (s)
      4'd3: return ~pad_buttons[7:0];
      4'd4: return ~pad_buttons[15:8];
      4'd5: return pad_sticks[2];
      4'd6: return pad_sticks[3];
      4'd7: return pad_sticks[0];
      default: return pad_sticks[1];
    endcase
  endfunction

  // One serial byte: reply and protocol state update
  function automatic logic [7:0] host_byte_reply(input logic [7:0] b);
    logic [3:0] s;
    logic [7:0] p;
    logic [7:0] r;
    logic [3:0] c;
    s = seq_step;
    p = cmd_arg;
    r = agsr_pkg::RX_IDLE;
    if (s == 4'd0) cur_cmd = agsr_pkg::CMD_NONE;
    if (cur_cmd != agsr_pkg::CMD_NONE) begin
      if (s < 4'd2 || s > 4'd8) return agsr_pkg::RX_IDLE;
      if (s == 4'd2) begin
        seq_step = 4'd3;
        return agsr_pkg::RX_ACK;
      end
      case (cur_cmd)
        agsr_pkg::CMD_ENTER, agsr_pkg::CMD_EXIT: begin
          if (s == 4'd3) pad_config = (b == 8'h01);
          r = (cur_cmd == agsr_pkg::CMD_ENTER) ? pad_report_byte(s) : 8'h00;
        end
        agsr_pkg::CMD_LEDSET: begin
          if (s == 4'd3) cmd_arg = b;
          if (s == 4'd4 && p == 8'h02) pad_lamp = (b == 8'h01);
          r = 8'h00;
        end
        agsr_pkg::CMD_LEDGET: begin
          case (s)
            4'd3, 4'd7: r = 8'h01;
            4'd4, 4'd6: r = 8'h02;
            4'd5: r = {7'd0, pad_lamp};
            default: r = 8'h00;
          endcase
        end
        agsr_pkg::CMD_RUMBLE: begin
          if (s == 4'd8) pad_analog = 1'b1;
          r = 8'h00;
        end
        agsr_pkg::CMD_X46: begin
          if (s == 4'd3) cmd_arg = b;
          case (s)
            4'd3, 4'd4: r = 8'h00;
            4'd5: r = 8'h01;
            4'd6: r = (p == 8'h01) ? 8'h01 : 8'h02;
            4'd7: r = (p == 8'h01) ? 8'h01 : 8'h00;
            default: r = (p == 8'h01) ? X46_ARG_ONE : X46_ARG_OTHER;
          endcase
        end
        agsr_pkg::CMD_X47: r = (s == 4'd5) ? 8'h02 : ((s == 4'd7) ? 8'h01 : 8'h00);
        agsr_pkg::CMD_X4C: begin
          if (s == 4'd3) cmd_arg = b;
          r = 8'h00;
          if (s == 4'd6) r = (p == 8'h01) ? X4C_ARG_ONE : X4C_ARG_OTHER;
        end
        default: r = pad_report_byte(s);
      endcase
      // digital reads and config entries stop after the two button bytes
      if (s == 4'd8) seq_step = 4'd0;
      else if (s == 4'd4 && !pad_analog &&
               (cur_cmd == agsr_pkg::CMD_READ || cur_cmd == agsr_pkg::CMD_ENTER))
        seq_step = 4'd0;
      else seq_step = s + 4'd1;
      return r;
    end
    if (s == 4'd0) begin
      if (b == agsr_pkg::HB_START) seq_step = 4'd1;
      return agsr_pkg::RX_IDLE;
    end
    if (s == 4'd1) begin
      c = agsr_pkg::CMD_NONE;
      if (b == agsr_pkg::HB_READ) c = agsr_pkg::CMD_READ;
      else if (b == agsr_pkg::HB_CONFIG)
        c = pad_config ? agsr_pkg::CMD_EXIT : agsr_pkg::CMD_ENTER;
      else if (pad_config) begin
        case (b)
          agsr_pkg::HB_LEDSET: c = agsr_pkg::CMD_LEDSET;
          agsr_pkg::HB_LEDGET: c = agsr_pkg::CMD_LEDGET;
          agsr_pkg::HB_X46:    c = agsr_pkg::CMD_X46;
          agsr_pkg::HB_X47:    c = agsr_pkg::CMD_X47;
          agsr_pkg::HB_RUMBLE: c = agsr_pkg::CMD_RUMBLE;
          agsr_pkg::HB_X4C:    c = agsr_pkg::CMD_X4C;
          default:             c = agsr_pkg::CMD_NONE;
        endcase
      end
      if (c == agsr_pkg::CMD_NONE) begin
        seq_step = 4'd0;
        return agsr_pkg::RX_IDLE;
      end
      cur_cmd  = c;
      seq_step = 4'd2;
      return pad_config ? agsr_pkg::ID_CONFIG :
             (pad_analog ? agsr_pkg::ID_ANALOG : agsr_pkg::ID_DIGITAL);
    end
    seq_step = 4'd0;
    return agsr_pkg::RX_IDLE;
  endfunction

  // Full reply to one request, with the flags after it
  function automatic agsr_pkg::agsr_result_t respond_to_item(input agsr_pkg::agsr_item_t it);
    agsr_pkg::agsr_result_t res;
    res.rx_byte    = agsr_pkg::RX_IDLE;
    res.more_bytes = 1'b0;
    case (it.opcode)
      agsr_pkg::OP_EXCHANGE: begin
        res.rx_byte    = host_byte_reply(it.tx_byte);
        res.more_bytes = (seq_step != 4'd0);
      end
      agsr_pkg::OP_SNAPSHOT: begin
        pad_buttons = it.pressed_buttons;
        if (it.mode_button) begin
          if (!mode_held) begin
            mode_held  = 1'b1;
            pad_analog = !pad_analog;
            pad_lamp   = pad_analog;
            seq_step   = 4'd0;
            cur_cmd    = agsr_pkg::CMD_NONE;
          end
        end else begin
          mode_held = 1'b0;
        end
        // digital mode: sticks frozen, L3/R3 dropped
        if (!pad_analog) begin
          pad_buttons[2:1] = 2'b00;
        end else begin
          pad_sticks[0] = it.left_stick_x;
          pad_sticks[1] = it.left_stick_y;
          pad_sticks[2] = it.right_stick_x;
          pad_sticks[3] = it.right_stick_y;
        end
      end
      agsr_pkg::OP_SEL_RELEASE: begin
        seq_step = 4'd0;
        cur_cmd  = agsr_pkg::CMD_NONE;
      end
      default: ;
    endcase
    res.analog_mode = pad_analog;
    res.led_on      = pad_lamp;
    res.config_mode = pad_config;
    return res;
  endfunction

  // Request builders for the directed table
  function automatic agsr_pkg::agsr_item_t xchg_item(input logic [7:0] b);
    agsr_pkg::agsr_item_t it;
    it         = '0;
    it.opcode  = agsr_pkg::OP_EXCHANGE;
    it.tx_byte = b;
    return it;
  endfunction

  function automatic agsr_pkg::agsr_item_t snap_item(input logic [15:0] btn,
                                                     input logic [7:0] stk,
                                                     input logic mb);
    agsr_pkg::agsr_item_t it;
    it                 = '0;
    it.opcode          = agsr_pkg::OP_SNAPSHOT;
    it.pressed_buttons = btn;
    it.left_stick_x    = stk;
    it.left_stick_y    = stk;
    it.right_stick_x   = stk;
    it.right_stick_y   = stk;
    it.mode_button     = mb;
    return it;
  endfunction

  function automatic agsr_pkg::agsr_item_t op_item(input logic [1:0] op);
    agsr_pkg::agsr_item_t it;
    it        = '1;
    it.opcode = op;
    return it;
  endfunction

  function automatic dir_row_t fixed_row(input agsr_pkg::agsr_item_t it, input logic [7:0] rx,
                                         input logic more, input logic [2:0] flags);
    dir_row_t row;
    row.item  = it;
    row.typed = 1'b1;
    row.want  = {rx, more, flags};
    return row;
  endfunction

  function automatic dir_row_t open_row(input agsr_pkg::agsr_item_t it);
    dir_row_t row;
    row.item  = it;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic agsr_pkg::agsr_item_t random_fields();
    agsr_pkg::agsr_item_t it;
    it.opcode          = 2'($urandom_range(0, 3));
    it.tx_byte         = 8'($urandom);
    it.pressed_buttons = 16'($urandom);
    it.left_stick_x    = 8'($urandom);
    it.left_stick_y    = 8'($urandom);
    it.right_stick_x   = 8'($urandom);
    it.right_stick_y   = 8'($urandom);
    it.mode_button     = 1'($urandom);
    return it;
  endfunction

  // Drive one request, wait for it to be taken, then log its reply
  task automatic send_request(input agsr_pkg::agsr_item_t item, input logic typed,
                              input agsr_pkg::agsr_result_t want);
    agsr_pkg::agsr_result_t predicted;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = respond_to_item(item);
    pending_replies.push_back(typed ? want : predicted);
    if (item.opcode != OP_RESERVED) sent_count++;
  endtask

  task automatic send_random(input agsr_pkg::agsr_item_t item);
    send_request(item, 1'b0, '0);
  endtask

  // Start byte, command byte, then payload until the pad ends the sequence
  task automatic send_sequence();
    agsr_pkg::agsr_item_t it;
    int         guard;
    int         pick;
    it         = random_fields();
    it.opcode  = agsr_pkg::OP_EXCHANGE;
    it.tx_byte = agsr_pkg::HB_START;
    send_random(it);
    it        = random_fields();
    it.opcode = agsr_pkg::OP_EXCHANGE;
    case ($urandom_range(0, 9))
      0: it.tx_byte = agsr_pkg::HB_READ;
      1, 2: it.tx_byte = agsr_pkg::HB_CONFIG;
      3: it.tx_byte = agsr_pkg::HB_LEDSET;
      4: it.tx_byte = agsr_pkg::HB_LEDGET;
      5: it.tx_byte = agsr_pkg::HB_X46;
      6: it.tx_byte = agsr_pkg::HB_X47;
      7: it.tx_byte = agsr_pkg::HB_X4C;
      8: it.tx_byte = agsr_pkg::HB_RUMBLE;
      default: it.tx_byte = 8'($urandom);
    endcase
    send_random(it);
    guard = 0;
    while (seq_step != 4'd0 && guard < 8) begin
      it        = random_fields();
      it.opcode = agsr_pkg::OP_EXCHANGE;
      // first payload byte decides mode and parameters
      pick = (seq_step == 4'd3) ? $urandom_range(0, 5) : $urandom_range(2, 5);
      case (pick)
        0, 1, 2: it.tx_byte = 8'h01;
        3: it.tx_byte = 8'h00;
        4: it.tx_byte = 8'h02;
        default: it.tx_byte = 8'($urandom);
      endcase
      // occasional break-in mid sequence
      if ($urandom_range(0, 39) == 0)
        it.opcode = ($urandom_range(0, 1) == 0) ? agsr_pkg::OP_SEL_RELEASE :
                                                  agsr_pkg::OP_SNAPSHOT;
      send_random(it);
      guard++;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Reply checker
  always @(posedge clk) begin
    agsr_pkg::agsr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, actual %h", $time, out_ch.data);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("rx_byte", want.rx_byte, out_ch.data.rx_byte);
        check_field("more_bytes", {7'd0, want.more_bytes},
                    {7'd0, out_ch.data.more_bytes});
        check_field("analog_mode", {7'd0, want.analog_mode},
                    {7'd0, out_ch.data.analog_mode});
        check_field("led_on", {7'd0, want.led_on}, {7'd0, out_ch.data.led_on});
        check_field("config_mode", {7'd0, want.config_mode},
                    {7'd0, out_ch.data.config_mode});
      end
    end
  end

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    agsr_pkg::agsr_item_t it;
    int         r;
    int         next_phase;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;

    // flags are {analog, led, config}
    directed_rows = '{
      fixed_row(xchg_item(8'h00), agsr_pkg::RX_IDLE, 1'b0, 3'b000),   // no start byte
      fixed_row(op_item(OP_RESERVED), agsr_pkg::RX_IDLE, 1'b0, 3'b000),
      fixed_row(xchg_item(agsr_pkg::HB_START), agsr_pkg::RX_IDLE, 1'b1, 3'b000),
      fixed_row(xchg_item(8'hFF), agsr_pkg::RX_IDLE, 1'b0, 3'b000),    // unknown command
      fixed_row(snap_item(16'hFFFF, 8'h00, 1'b0), agsr_pkg::RX_IDLE, 1'b0, 3'b000),
      fixed_row(xchg_item(agsr_pkg::HB_START), agsr_pkg::RX_IDLE, 1'b1, 3'b000),
      fixed_row(xchg_item(agsr_pkg::HB_READ), agsr_pkg::ID_DIGITAL, 1'b1, 3'b000),
      fixed_row(xchg_item(8'h00), agsr_pkg::RX_ACK, 1'b1, 3'b000),
      fixed_row(xchg_item(8'h00), 8'h06, 1'b1, 3'b000),      // L3/R3 cleared
      fixed_row(xchg_item(8'h00), 8'h00, 1'b0, 3'b000),      // digital read ends
      fixed_row(snap_item(16'h0000, 8'hFF, 1'b1), agsr_pkg::RX_IDLE, 1'b0, 3'b110),
      fixed_row(snap_item(16'hAAAA, 8'h00, 1'b1), agsr_pkg::RX_IDLE, 1'b0, 3'b110),
      fixed_row(xchg_item(agsr_pkg::HB_START), agsr_pkg::RX_IDLE, 1'b1, 3'b110),
      fixed_row(xchg_item(agsr_pkg::HB_READ), agsr_pkg::ID_ANALOG, 1'b1, 3'b110),
      open_row(xchg_item(8'h00)),
      open_row(xchg_item(8'h00)),
      fixed_row(op_item(agsr_pkg::OP_SEL_RELEASE), agsr_pkg::RX_IDLE, 1'b0, 3'b110),
      open_row(xchg_item(agsr_pkg::HB_START)),
      fixed_row(xchg_item(agsr_pkg::HB_CONFIG), agsr_pkg::ID_ANALOG, 1'b1, 3'b110),
      open_row(xchg_item(8'h00)),
      open_row(xchg_item(8'h01)),
      open_row(snap_item(16'h1234, 8'h3C, 1'b0)),
      fixed_row(snap_item(16'h0000, 8'hC3, 1'b1), agsr_pkg::RX_IDLE, 1'b0, 3'b001),
      open_row(xchg_item(agsr_pkg::HB_START)),
      fixed_row(xchg_item(agsr_pkg::HB_RUMBLE), agsr_pkg::ID_CONFIG, 1'b1, 3'b001),
      open_row(xchg_item(8'h00))
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < 26; i++)
      send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Hold off until every reply so far is back
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);

    // Random traffic in phases, calm at the end
    sent_count = 0;
    next_phase = 60;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= ITEM_TARGET - CALM_TAIL) begin
        idle_enable = 1'b0;
      end else if (sent_count >= next_phase) begin
        idle_enable = ($urandom_range(0, 3) != 0);
        next_phase += 60;
      end
      r  = $urandom_range(0, 19);
      it = random_fields();
      if (r < 12) begin
        send_sequence();
      end else begin
        if (r < 15) begin
          it.opcode      = agsr_pkg::OP_SNAPSHOT;
          it.mode_button = ($urandom_range(0, 3) == 0);
        end else if (r == 15) begin
          it.opcode = agsr_pkg::OP_SEL_RELEASE;
        end else if (r == 16) begin
          it.opcode = OP_RESERVED;
        end else begin
          it.opcode = agsr_pkg::OP_EXCHANGE;
        end
        send_random(it);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
